// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/cacr_pkg.sv -----
// ----------------------------------------------------------------------------
// cacr_pkg
// Types and constants for the circle versus box contact resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package cacr_pkg;

    localparam int CB  = 24;          // coordinate bits
    localparam int UB  = CB - 1;      // radius / half size bits
    localparam int D2B = 2 * UB;      // squared distance bits
    localparam int NB  = 16;          // normal bits
    localparam int NMB = 15;          // normal magnitude bits
    localparam int PB  = UB + NMB;    // pen * |n| bits

    localparam logic [NMB-1:0] NORM_ONE  = NMB'(16384);
    localparam logic [NMB-1:0] NORM_DIAG = NMB'(11585);

    typedef struct packed {
        logic signed [CB-1:0] circle_x;
        logic signed [CB-1:0] circle_y;
        logic        [UB-1:0] circle_radius;
        logic signed [CB-1:0] box_x;
        logic signed [CB-1:0] box_y;
        logic        [UB-1:0] box_half_w;
        logic        [UB-1:0] box_half_h;
        logic                 circle_dynamic;
        logic                 box_dynamic;
    } item_t;

    typedef struct packed {
        logic                 contact;
        logic signed [NB-1:0] normal_x;
        logic signed [NB-1:0] normal_y;
        logic signed [CB-1:0] circle_dx;
        logic signed [CB-1:0] circle_dy;
        logic signed [CB-1:0] box_dx;
        logic signed [CB-1:0] box_dy;
    } result_t;

    // axis side of the circle centre relative to the box
    typedef struct packed {
        logic outside;
        logic neg;
    } side_t;

    // classified pair handed from front to back
    typedef struct packed {
        logic           contact;
        side_t          side_x;
        side_t          side_y;
        logic [UB-1:0]  radius;
        logic [D2B-1:0] d2;
        logic           cdyn;
        logic           bdyn;
    } task_t;

endpackage

`default_nettype wire

// ----- rtl/cacr_fifo.sv -----
// ----------------------------------------------------------------------------
// cacr_fifo
// Small synchronous queue, power-of-two depth, full flag decoded from the registered count.
// ----------------------------------------------------------------------------
`default_nettype none

module cacr_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire T     wdata,
    output logic      full,
    input  wire logic pop,
    output T          rdata,
    output logic      empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    T               mem [DEPTH];
    logic [AW-1:0]  wptr_reg, rptr_reg;
    logic [AW:0]    count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cacr_front.sv -----
// ----------------------------------------------------------------------------
// cacr_front
// Early reject, clamp to box, squared distance and contact test.
// ----------------------------------------------------------------------------
`default_nettype none

module cacr_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire cacr_pkg::item_t item,
    output logic                 full,
    output logic                 task_push,
    output cacr_pkg::task_t      task_data,
    input  wire logic            task_full
);

    import cacr_pkg::*;

    logic adv;

    // stage 1: relative position
    logic                 v1_reg;
    logic signed [CB:0]   rx1_reg, ry1_reg;
    logic [UB-1:0]        r1_reg, hw1_reg, hh1_reg;
    logic                 cd1_reg, bd1_reg;

    // stage 2: clamp
    logic                 v2_reg;
    logic                 pre2_reg;
    logic [UB-1:0]        dx2_reg, dy2_reg, r2_reg;
    side_t                sx2_reg, sy2_reg;
    logic                 cd2_reg, bd2_reg;

    // stage 3: squares
    logic                 v3_reg;
    logic                 pre3_reg;
    logic [D2B-1:0]       sqx3_reg, sqy3_reg, rr3_reg;
    logic [UB-1:0]        r3_reg;
    side_t                sx3_reg, sy3_reg;
    logic                 cd3_reg, bd3_reg;

    logic [CB:0]          ax, ay;
    logic [CB:0]          lim_x, lim_y;
    logic signed [CB+1:0] hw_s, hh_s;
    logic signed [CB+1:0] ox_pos, ox_neg, oy_pos, oy_neg;
    logic [UB-1:0]        dx, dy;
    side_t                sx, sy;
    logic [D2B:0]         d2;

    assign adv  = !(v3_reg && task_full);
    assign full = !adv;

    always_comb
    begin
        ax    = rx1_reg[CB] ? (CB+1)'(-rx1_reg) : (CB+1)'(rx1_reg);
        ay    = ry1_reg[CB] ? (CB+1)'(-ry1_reg) : (CB+1)'(ry1_reg);
        lim_x = (CB+1)'(hw1_reg) + (CB+1)'(r1_reg);
        lim_y = (CB+1)'(hh1_reg) + (CB+1)'(r1_reg);
        hw_s  = (CB+2)'(signed'({1'b0, hw1_reg}));
        hh_s  = (CB+2)'(signed'({1'b0, hh1_reg}));
        ox_pos = (CB+2)'(rx1_reg) - hw_s;
        ox_neg = -hw_s - (CB+2)'(rx1_reg);
        oy_pos = (CB+2)'(ry1_reg) - hh_s;
        oy_neg = -hh_s - (CB+2)'(ry1_reg);
        dx = '0;
        dy = '0;
        sx = '0;
        sy = '0;
        // distances fit UB bits whenever the pair is not rejected
        if (ox_pos > 0)
        begin
            dx = ox_pos[UB-1:0];
            sx = '{outside: 1'b1, neg: 1'b0};
        end
        else if (ox_neg > 0)
        begin
            dx = ox_neg[UB-1:0];
            sx = '{outside: 1'b1, neg: 1'b1};
        end
        if (oy_pos > 0)
        begin
            dy = oy_pos[UB-1:0];
            sy = '{outside: 1'b1, neg: 1'b0};
        end
        else if (oy_neg > 0)
        begin
            dy = oy_neg[UB-1:0];
            sy = '{outside: 1'b1, neg: 1'b1};
        end
    end

    assign d2 = (D2B+1)'(sqx3_reg) + (D2B+1)'(sqy3_reg);

    always_comb
    begin
        task_push         = v3_reg && adv;
        task_data.contact = pre3_reg && (d2 < (D2B+1)'(rr3_reg));
        task_data.side_x  = sx3_reg;
        task_data.side_y  = sy3_reg;
        task_data.radius  = r3_reg;
        task_data.d2      = d2[D2B-1:0];
        task_data.cdyn    = cd3_reg;
        task_data.bdyn    = bd3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx1_reg <= (CB+1)'(item.circle_x) - (CB+1)'(item.box_x);
            ry1_reg <= (CB+1)'(item.circle_y) - (CB+1)'(item.box_y);
            r1_reg  <= item.circle_radius;
            hw1_reg <= item.box_half_w;
            hh1_reg <= item.box_half_h;
            cd1_reg <= item.circle_dynamic;
            bd1_reg <= item.box_dynamic;

            pre2_reg <= !((ax > lim_x) || (ay > lim_y));
            dx2_reg  <= dx;
            dy2_reg  <= dy;
            r2_reg   <= r1_reg;
            sx2_reg  <= sx;
            sy2_reg  <= sy;
            cd2_reg  <= cd1_reg;
            bd2_reg  <= bd1_reg;

            pre3_reg <= pre2_reg;
            sqx3_reg <= D2B'(dx2_reg) * D2B'(dx2_reg);
            sqy3_reg <= D2B'(dy2_reg) * D2B'(dy2_reg);
            rr3_reg  <= D2B'(r2_reg) * D2B'(r2_reg);
            r3_reg   <= r2_reg;
            sx3_reg  <= sx2_reg;
            sy3_reg  <= sy2_reg;
            cd3_reg  <= cd2_reg;
            bd3_reg  <= bd2_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cacr_back.sv -----
// ----------------------------------------------------------------------------
// cacr_back
// Pipelined integer square root, penetration and separation moves.
// ----------------------------------------------------------------------------
`default_nettype none

module cacr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              task_empty,
    input  wire cacr_pkg::task_t   task_data,
    output logic                   task_pop,
    output logic                   res_push,
    output cacr_pkg::result_t      res_data,
    input  wire logic              res_full
);

    import cacr_pkg::*;

    localparam int NS = UB;           // one root bit per stage

    logic adv;

    logic           sv_reg  [NS];
    task_t          st_reg  [NS];
    logic [D2B:0]   rem_reg [NS];
    logic [D2B:0]   root_reg[NS];

    // move stage
    logic              mv_reg;
    logic              mc_reg;
    side_t             msx_reg, msy_reg;
    logic              mcd_reg, mbd_reg;
    logic [NMB-1:0]    anx_reg, any_reg;
    logic [PB-1:0]     px_reg, py_reg;

    logic [UB-1:0]     pen;
    logic [NMB-1:0]    anx, any_n;

    assign adv      = !(mv_reg && res_full);
    assign task_pop = adv;

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_root
            localparam logic [D2B:0] BIT = (D2B+1)'(1) << (2 * (NS - 1 - k));
            logic [D2B:0] rem_in, root_in, trial;
            logic         v_in;
            task_t        t_in;
            if (k == 0)
            begin : g_first
                assign rem_in  = (D2B+1)'(task_data.d2);
                assign root_in = '0;
                assign v_in    = !task_empty;
                assign t_in    = task_data;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign v_in    = sv_reg[k-1];
                assign t_in    = st_reg[k-1];
            end
            assign trial = root_in + BIT;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sv_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    sv_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    st_reg[k] <= t_in;
                    if (rem_in >= trial)
                    begin
                        rem_reg[k]  <= rem_in - trial;
                        root_reg[k] <= (root_in >> 1) + BIT;
                    end
                    else
                    begin
                        rem_reg[k]  <= rem_in;
                        root_reg[k] <= root_in >> 1;
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        pen   = st_reg[NS-1].radius - root_reg[NS-1][UB-1:0];
        anx   = '0;
        any_n = '0;
        if (st_reg[NS-1].side_x.outside && st_reg[NS-1].side_y.outside)
        begin
            anx   = NORM_DIAG;
            any_n = NORM_DIAG;
        end
        else
        begin
            anx   = st_reg[NS-1].side_x.outside ? NORM_ONE : '0;
            any_n = st_reg[NS-1].side_y.outside ? NORM_ONE : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
        end
        else if (adv)
        begin
            mv_reg <= sv_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mc_reg  <= st_reg[NS-1].contact;
            msx_reg <= st_reg[NS-1].side_x;
            msy_reg <= st_reg[NS-1].side_y;
            mcd_reg <= st_reg[NS-1].cdyn;
            mbd_reg <= st_reg[NS-1].bdyn;
            anx_reg <= anx;
            any_reg <= any_n;
            px_reg  <= PB'(pen) * PB'(anx);
            py_reg  <= PB'(pen) * PB'(any_n);
        end
    end

    // round half away from zero on the magnitude, then saturate
    function automatic logic signed [CB-1:0] move_mag(input logic [PB-1:0] p,
                                                      input logic both);
        logic [PB:0]   sum;
        logic [PB:0]   q;
        sum = both ? ((PB+1)'(p) + (PB+1)'(1 << 14)) : ((PB+1)'(p) + (PB+1)'(1 << 13));
        q   = both ? (sum >> 15) : (sum >> 14);
        if (q > (PB+1)'({1'b0, {UB{1'b1}}}))
        begin
            q = (PB+1)'({1'b0, {UB{1'b1}}});
        end
        return q[CB-1:0];
    endfunction

    logic signed [CB-1:0] mag_x, mag_y, cmx, cmy;
    logic                 both;

    always_comb
    begin
        both  = mcd_reg && mbd_reg;
        mag_x = move_mag(px_reg, both);
        mag_y = move_mag(py_reg, both);
        cmx   = msx_reg.neg ? -mag_x : mag_x;
        cmy   = msy_reg.neg ? -mag_y : mag_y;

        res_push           = mv_reg && adv;
        res_data           = '0;
        if (mc_reg)
        begin
            res_data.contact  = 1'b1;
            res_data.normal_x = msx_reg.neg ? -NB'(anx_reg) : NB'(anx_reg);
            res_data.normal_y = msy_reg.neg ? -NB'(any_reg) : NB'(any_reg);
            if (mcd_reg)
            begin
                res_data.circle_dx = cmx;
                res_data.circle_dy = cmy;
            end
            if (mbd_reg)
            begin
                res_data.box_dx = -cmx;
                res_data.box_dy = -cmy;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/circle_aabb_contact_resolve.sv -----
// Path: front stages, task queue, root stages and move stage of the back,
//   then the result queue to the ports.
// Throughput: one pair per cycle while the task queue has room; the back pipeline is one root bit per stage.
// Reset: rst_n asynchronous, active low; clears all valid flags and queues.
// ----------------------------------------------------------------------------
// circle_aabb_contact_resolve
// Circle versus axis-aligned box contact test and separation moves.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_aabb_contact_resolve (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire cacr_pkg::item_t   item,
    output logic                   full,
    input  wire logic              pop,
    output cacr_pkg::result_t      result,
    output logic                   empty
);

    import cacr_pkg::*;

`include "assert_macros.svh"

    logic    task_push, task_full, task_pop, task_empty;
    task_t   task_in, task_out;
    logic    res_push, res_full;
    result_t res_in;

    cacr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .task_push (task_push),
        .task_data (task_in),
        .task_full (task_full)
    );

    cacr_fifo #(.T(task_t), .DEPTH(4)) u_task_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (task_push),
        .wdata (task_in),
        .full  (task_full),
        .pop   (task_pop),
        .rdata (task_out),
        .empty (task_empty)
    );

    cacr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_empty (task_empty),
        .task_data  (task_out),
        .task_pop   (task_pop),
        .res_push   (res_push),
        .res_data   (res_in),
        .res_full   (res_full)
    );

    cacr_fifo #(.T(result_t), .DEPTH(2)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    `ASSERT_IMPL(a_no_contact_zero, clk, rst_n, !empty && !result.contact,
        result.normal_x == 0 && result.normal_y == 0 && result.circle_dx == 0 && result.box_dx == 0)
    `ASSERT_IMPL(a_inside_no_move, clk, rst_n,
        !empty && result.normal_x == 0 && result.normal_y == 0,
        result.circle_dx == 0 && result.circle_dy == 0 && result.box_dy == 0)
    `ASSERT_IMPL(a_moves_opposite, clk, rst_n,
        !empty && result.circle_dx != 0 && result.box_dx != 0,
        result.circle_dx == -result.box_dx)
    `ASSERT_NEXT(a_queue_no_drop, clk, rst_n, task_push && task_full, 1'b0)

endmodule

`default_nettype wire

// ----- sim/contact_checker.sv -----
// ----------------------------------------------------------------------------
// contact_checker
// Watches the pair and result queues of the contact resolver, computes the
// contact, normal and separation moves for each pair taken in, and compares
// every result taken out against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module contact_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic              full,
    input  wire cacr_pkg::item_t   item,
    input  wire logic              pop,
    input  wire logic              empty,
    input  wire cacr_pkg::result_t result,
    output int                     fails,
    output int                     pending,
    output logic                   moved
);

    import cacr_pkg::*;

    localparam longint NORM_AXIS = 16384;
    localparam longint NORM_DIAGONAL = 11585;
    localparam longint MOVE_LIMIT = (longint'(1) << (CB - 1)) - 1;

    result_t expected_contacts[$];

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = longint'(1) << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    // sign(n) * round(pen*|n| / 2^shift), ties away from zero, saturated
    function automatic logic [CB-1:0] axis_shift(longint pen, longint n, int shift);
        longint an;
        longint mag;
        an = (n < 0) ? -n : n;
        mag = (pen * an + (longint'(1) << (shift - 1))) >>> shift;
        if (mag > MOVE_LIMIT)
            mag = MOVE_LIMIT;
        return CB'((n < 0) ? -mag : mag);
    endfunction

    function automatic result_t resolve_contact(item_t it);
        result_t res;
        longint rx, ry, ax, ay, hw, hh, r, dx, dy, sx, sy, nx, ny, pen;
        longint unsigned d2;
        int shift;
        res = '0;
        r  = longint'(it.circle_radius);
        hw = longint'(it.box_half_w);
        hh = longint'(it.box_half_h);
        rx = longint'(it.circle_x) - longint'(it.box_x);
        ry = longint'(it.circle_y) - longint'(it.box_y);
        ax = (rx < 0) ? -rx : rx;
        ay = (ry < 0) ? -ry : ry;
        dx = 0; dy = 0; sx = 0; sy = 0;
        if (ax > hw + r || ay > hh + r)
            return res;
        if (rx > hw) begin dx = rx - hw; sx = 1; end
        else if (rx < -hw) begin dx = -hw - rx; sx = -1; end
        if (ry > hh) begin dy = ry - hh; sy = 1; end
        else if (ry < -hh) begin dy = -hh - ry; sy = -1; end
        d2 = dx * dx + dy * dy;
        if (d2 >= longint'(r * r))
            return res;
        if (sx != 0 && sy != 0)
        begin
            nx = sx * NORM_DIAGONAL;
            ny = sy * NORM_DIAGONAL;
        end
        else
        begin
            nx = sx * NORM_AXIS;
            ny = sy * NORM_AXIS;
        end
        pen = r - longint'(floor_sqrt(d2));
        shift = (it.circle_dynamic && it.box_dynamic) ? 15 : 14;
        res.contact  = 1'b1;
        res.normal_x = NB'(nx);
        res.normal_y = NB'(ny);
        if (it.circle_dynamic)
        begin
            res.circle_dx = axis_shift(pen, nx, shift);
            res.circle_dy = axis_shift(pen, ny, shift);
        end
        if (it.box_dynamic)
        begin
            res.box_dx = axis_shift(pen, -nx, shift);
            res.box_dy = axis_shift(pen, -ny, shift);
        end
        return res;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
        fails++;
    endtask

    initial
    begin
        fails = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        result_t want;
        moved <= 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                expected_contacts.push_back(resolve_contact(item));
                moved <= 1'b1;
            end
            if (pop && !empty)
            begin
                moved <= 1'b1;
                if (expected_contacts.size() == 0)
                    report("unexpected result, contact", result.contact, 0);
                else
                begin
                    want = expected_contacts.pop_front();
                    if (result.contact !== want.contact)
                        report("contact", result.contact, want.contact);
                    if (result.normal_x !== want.normal_x)
                        report("normal_x", result.normal_x, want.normal_x);
                    if (result.normal_y !== want.normal_y)
                        report("normal_y", result.normal_y, want.normal_y);
                    if (result.circle_dx !== want.circle_dx)
                        report("circle_dx", result.circle_dx, want.circle_dx);
                    if (result.circle_dy !== want.circle_dy)
                        report("circle_dy", result.circle_dy, want.circle_dy);
                    if (result.box_dx !== want.box_dx)
                        report("box_dx", result.box_dx, want.box_dx);
                    if (result.box_dy !== want.box_dy)
                        report("box_dy", result.box_dy, want.box_dy);
                end
            end
            pending = expected_contacts.size();
        end
    end

endmodule

`default_nettype wire

// ----- sim/circle_aabb_contact_resolve_tb.sv -----
// ----------------------------------------------------------------------------
// circle_aabb_contact_resolve_tb
// Streams directed and random circle/box pairs into the resolver under
// several sender idle and receiver stall mixes; the checker predicts and
// compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_aabb_contact_resolve_tb;
    import cacr_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int PAIRS_PER_PHASE = 390;
    localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
    localparam longint CMIN = -(longint'(1) << (CB - 1));
    localparam longint UMAX = (longint'(1) << UB) - 1;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    item_t   item = '0;
    logic    full;
    logic    pop = 1'b0;
    result_t result;
    logic    empty;
    int      fails;
    int      pending;
    logic    moved;
    int      send_idle_pct = 0;
    int      pop_stall_pct = 0;
    int      quiet_cycles = 0;

    always #5 clk = ~clk;

    circle_aabb_contact_resolve dut (
        .clk(clk), .rst_n(rst_n), .push(push), .item(item), .full(full),
        .pop(pop), .result(result), .empty(empty)
    );

    contact_checker checker_i (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .pop(pop), .empty(empty), .result(result), .fails(fails),
        .pending(pending), .moved(moved)
    );

    always @(posedge clk)
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);

    always @(posedge clk)
    begin
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic item_t make_pair(longint cx, longint cy, longint r, longint bx,
                                        longint by, longint hw, longint hh,
                                        bit cd, bit bd);
        item_t it;
        it.circle_x = CB'(cx);
        it.circle_y = CB'(cy);
        it.circle_radius = UB'(r);
        it.box_x = CB'(bx);
        it.box_y = CB'(by);
        it.box_half_w = UB'(hw);
        it.box_half_h = UB'(hh);
        it.circle_dynamic = cd;
        it.box_dynamic = bd;
        return it;
    endfunction

    task automatic send(item_t it);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
    endtask

    // mostly pairs near touching, with random content; some full-range noise
    function automatic item_t random_pair();
        item_t it;
        logic [191:0] noise;
        longint bx, by, hw, hh, r, spanx, spany;
        if ($urandom_range(0, 99) < 10)
        begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            it = noise[$bits(item_t)-1:0];
            return it;
        end
        bx = longint'($urandom_range(0, 2 * 1048576)) - 1048576;
        by = longint'($urandom_range(0, 2 * 1048576)) - 1048576;
        hw = longint'($urandom_range(0, 4096));
        hh = longint'($urandom_range(0, 4096));
        r  = longint'($urandom_range(0, 4096));
        if ($urandom_range(0, 49) == 0)
        begin
            hw = longint'($urandom_range(0, 32'(UMAX / 4)));
            r  = longint'($urandom_range(0, 32'(UMAX / 4)));
        end
        spanx = hw + r + 64;
        spany = hh + r + 64;
        return make_pair(bx + longint'($urandom_range(0, 32'(2 * spanx))) - spanx,
                         by + longint'($urandom_range(0, 32'(2 * spany))) - spany,
                         r, bx, by, hw, hh,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    initial
    begin
        item_t directed[$];
        int ph;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, inside box, zero radius, axis and diagonal normals,
        // every dynamic mix
        directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 1, 1));
        directed.push_back(make_pair(CMAX, CMAX, UMAX, CMIN, CMIN, UMAX, UMAX, 1, 1));
        directed.push_back(make_pair(CMIN, CMIN, UMAX, CMAX, CMAX, 0, 0, 1, 0));
        directed.push_back(make_pair(CMAX, 0, UMAX, CMIN, 0, UMAX, 0, 0, 1));
        directed.push_back(make_pair(10, 20, 100, 0, 0, 200, 200, 1, 1));
        directed.push_back(make_pair(10, 20, 0, 0, 0, 200, 200, 1, 1));
        directed.push_back(make_pair(250, 0, 100, 0, 0, 200, 200, 1, 1));
        directed.push_back(make_pair(-250, 0, 100, 0, 0, 200, 200, 1, 0));
        directed.push_back(make_pair(0, 250, 100, 0, 0, 200, 200, 0, 1));
        directed.push_back(make_pair(0, -250, 100, 0, 0, 200, 200, 0, 0));
        directed.push_back(make_pair(230, 230, 100, 0, 0, 200, 200, 1, 1));
        directed.push_back(make_pair(-230, 230, 100, 0, 0, 200, 200, 1, 0));
        directed.push_back(make_pair(230, -230, 100, 0, 0, 200, 200, 0, 1));
        directed.push_back(make_pair(-230, -230, 100, 0, 0, 200, 200, 1, 1));
        directed.push_back(make_pair(300, 0, 100, 0, 0, 200, 200, 1, 1));
        directed.push_back(make_pair(271, 271, 100, 0, 0, 200, 200, 1, 1));
        directed.push_back(make_pair(301, 0, 100, 0, 0, 200, 200, 1, 1));
        directed.push_back(make_pair(201, 0, 1, 0, 0, 200, 200, 1, 1));
        directed.push_back(make_pair(1, 0, 3, 0, 0, 0, 0, 1, 1));
        directed.push_back(make_pair(CMAX, CMAX, UMAX, CMAX - UMAX, CMAX - UMAX, 0, 0, 1, 0));
        directed.push_back(make_pair(-1, -1, UMAX, 0, 0, UMAX, UMAX, 1, 1));
        foreach (directed[i])
            send(directed[i]);
        push <= 1'b0;
        // let the checker log the last transfer before looking at the count
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 84 : (ph == 3) ? 16 : 0;
            pop_stall_pct = (ph == 2) ? 84 : (ph == 3) ? 16 : 0;
            repeat (PAIRS_PER_PHASE)
                send(random_pair());
        end
        push <= 1'b0;
        pop_stall_pct = 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/cacr_pkg.sv
rtl/cacr_fifo.sv
rtl/cacr_front.sv
rtl/cacr_back.sv
rtl/circle_aabb_contact_resolve.sv
sim/contact_checker.sv
sim/circle_aabb_contact_resolve_tb.sv
